// File: sv/ewcq_pkg.sv
// ---------------------------------------------------------------------------
// ewcq_pkg - shared types and constants of the eeprom write coalescing queue
// command and status codes, default sizes, bus address helper
// ---------------------------------------------------------------------------
package ewcq_pkg;

  // defaults for the top level parameters
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ADDR_BITS_DEF   = 11;

  // full width of an eeprom byte address on the request channel
  localparam int EE_ADDR_W = 11;

  // device address base, 7-bit address 0x50 shifted left once
  localparam logic [7:0] DEV_BASE = 8'hA0;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_LEAVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_NEW    = 2'd0,
    ST_MERGED = 2'd1,
    ST_FULL   = 2'd2,
    ST_DONE   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_FLUSH = 1'b1
  } state_t;

  // per-cell control from the queue controller
  typedef struct packed {
    logic pop;  // take the entry of the next younger neighbor
    logic wr;   // write the incoming request into this cell
  } cell_ctrl_t;

  // bus device address: base with address bits 10:8 in bits 3:1
  function automatic logic [7:0] dev_addr(input logic [EE_ADDR_W-1:0] a);
    dev_addr = DEV_BASE | {4'b0000, a[10:8], 1'b0};
  endfunction

endpackage

// File: sv/ewcq_if.sv
// ---------------------------------------------------------------------------
// ewcq_if - request and result channels of the write coalescing queue
// valid/ready handshake, payload as named fields
// ---------------------------------------------------------------------------
interface ewcq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [10:0] byte_addr;
  logic [7:0]  byte_data;

  modport source (output valid, cmd, byte_addr, byte_data, input ready);
  modport sink   (input valid, cmd, byte_addr, byte_data, output ready);
endinterface

interface ewcq_rsp_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] device_addr;
  logic [7:0] mem_addr;
  logic [7:0] tx_data;
  logic [1:0] status;
  logic       queue_empty;
  logic       last;

  modport source (output valid, tx_valid, device_addr, mem_addr, tx_data, status,
                  queue_empty, last, input ready);
  modport sink   (input valid, tx_valid, device_addr, mem_addr, tx_data, status,
                  queue_empty, last, output ready);
endinterface

// File: sv/ewcq_cell.sv
// ---------------------------------------------------------------------------
// ewcq_cell - one slot of the write queue
// holds address and data, shifts toward the head on pop, flags an address hit
// ---------------------------------------------------------------------------
module ewcq_cell
  import ewcq_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic                 occupied,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [7:0]           wr_data,
  input  logic [ADDR_BITS-1:0] nb_addr,
  input  logic [7:0]           nb_data,
  output logic [ADDR_BITS-1:0] addr,
  output logic [7:0]           data,
  output logic                 match
);

  // slot contents, no reset: only occupied slots are read
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      addr <= nb_addr;
      data <= nb_data;
    end else if (ctrl.wr) begin
      addr <= wr_addr;
      data <= wr_data;
    end
  end

  // address hit on a live entry
  assign match = occupied && (addr == wr_addr);

endmodule

// File: sv/eeprom_write_coalescing_queue_unit.sv
// ---------------------------------------------------------------------------
// eeprom_write_coalescing_queue_unit - posted write queue for a serial eeprom
// row of slot cells, writes to a queued address merge, ticks and flushes pop
// ---------------------------------------------------------------------------
// result: registered in the result register when its request is accepted
// throughput: one request per cycle for write, tick and leave while the result
//   register is free; a flush blocks requests and drains one result per cycle
//   while rsp.ready, paced by the single result register and the row's one-step shift
// reset: synchronous; the queue is emptied and queued mode selected, slot
//   contents are not cleared
module eeprom_write_coalescing_queue_unit
  import ewcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ewcq_req_if.sink   req,
  ewcq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t               state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic                 direct, direct_next;

  logic                 out_valid;
  logic                 out_tx_valid;
  logic [7:0]           out_device_addr;
  logic [7:0]           out_mem_addr;
  logic [7:0]           out_tx_data;
  status_t              out_status;
  logic                 out_queue_empty;
  logic                 out_last;

  logic                 out_free;
  logic                 accept;
  cmd_t                 cmd;
  logic [ADDR_BITS-1:0] in_addr;

  // result computed this cycle
  logic                 load;
  logic                 res_tx;
  logic [ADDR_BITS-1:0] res_addr;
  logic [7:0]           res_data;
  status_t              res_status;
  logic                 res_last;
  logic                 do_pop;
  logic                 do_append;
  logic                 do_merge;

  logic [ADDR_BITS-1:0] cell_addr [QUEUE_DEPTH];
  logic [7:0]           cell_data [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_match;
  logic [QUEUE_DEPTH-1:0] cell_occ;
  logic                 any_match;
  logic                 full;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign cmd       = cmd_t'(req.cmd);
  assign in_addr   = req.byte_addr[ADDR_BITS-1:0];
  assign any_match = |cell_match;
  assign full      = (count == CNT_W'(QUEUE_DEPTH));

  // row of slot cells, cell 0 holds the oldest entry
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t           ctrl;
    logic [ADDR_BITS-1:0] nb_addr;
    logic [7:0]           nb_data;

    assign cell_occ[i] = (count > CNT_W'(i));
    assign ctrl.pop    = do_pop;
    assign ctrl.wr     = (do_merge && cell_match[i]) ||
                         (do_append && (count == CNT_W'(i)));

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nb_addr = '0;
      assign nb_data = '0;
    end else begin : g_link
      assign nb_addr = cell_addr[i+1];
      assign nb_data = cell_data[i+1];
    end

    ewcq_cell #(
      .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (cell_occ[i]),
      .wr_addr  (in_addr),
      .wr_data  (req.byte_data),
      .nb_addr  (nb_addr),
      .nb_data  (nb_data),
      .addr     (cell_addr[i]),
      .data     (cell_data[i]),
      .match    (cell_match[i])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (cmd == CMD_FLUSH) && (count > CNT_W'(1))) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (out_free && (count == CNT_W'(1))) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // request decode and result selection
  always_comb begin
    load        = 1'b0;
    res_tx      = 1'b0;
    res_addr    = '0;
    res_data    = '0;
    res_status  = ST_DONE;
    res_last    = 1'b1;
    do_pop      = 1'b0;
    do_append   = 1'b0;
    do_merge    = 1'b0;
    direct_next = direct;
    count_next  = count;
    case (state)
      S_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (cmd)
            CMD_WRITE: begin
              if (direct) begin
                res_tx   = 1'b1;
                res_addr = in_addr;
                res_data = req.byte_data;
              end else if (any_match) begin
                do_merge   = 1'b1;
                res_status = ST_MERGED;
              end else if (!full) begin
                do_append  = 1'b1;
                count_next = count + CNT_W'(1);
                res_status = ST_NEW;
              end else begin
                res_status = ST_FULL;
              end
            end
            CMD_TICK: begin
              if (count != '0) begin
                do_pop     = 1'b1;
                count_next = count - CNT_W'(1);
                res_tx     = 1'b1;
                res_addr   = cell_addr[0];
                res_data   = cell_data[0];
              end
            end
            CMD_FLUSH: begin
              direct_next = 1'b1;
              if (count != '0) begin
                do_pop     = 1'b1;
                count_next = count - CNT_W'(1);
                res_tx     = 1'b1;
                res_addr   = cell_addr[0];
                res_data   = cell_data[0];
                res_last   = (count == CNT_W'(1));
              end
            end
            CMD_LEAVE: begin
              direct_next = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_FLUSH: begin
        // drain one entry per free result slot
        if (out_free) begin
          load       = 1'b1;
          do_pop     = 1'b1;
          count_next = count - CNT_W'(1);
          res_tx     = 1'b1;
          res_addr   = cell_addr[0];
          res_data   = cell_data[0];
          res_last   = (count == CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      direct    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      direct <= direct_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_tx_valid    <= res_tx;
      out_device_addr <= res_tx ? dev_addr(EE_ADDR_W'(res_addr)) : 8'h00;
      out_mem_addr    <= res_tx ? res_addr[7:0] : 8'h00;
      out_tx_data     <= res_data;
      out_status      <= res_status;
      out_queue_empty <= (count_next == '0);
      out_last        <= res_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.tx_valid    = out_tx_valid;
  assign rsp.device_addr = out_device_addr;
  assign rsp.mem_addr    = out_mem_addr;
  assign rsp.tx_data     = out_tx_data;
  assign rsp.status      = out_status;
  assign rsp.queue_empty = out_queue_empty;
  assign rsp.last        = out_last;

  // queue never exceeds its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // a flush run always has an entry left to drain
  a_flush_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> (count != '0))
    else $error("flush run with empty queue");

  // once a flush has drained, direct mode holds an empty queue
  a_direct_empty: assert property (@(posedge clk) disable iff (rst)
    (direct && (state == S_IDLE)) |-> (count == '0))
    else $error("entries queued in direct mode");

  // no request is taken while a flush run drains
  a_no_accept_flush: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> !req.ready)
    else $error("request taken during flush");

endmodule

// File: dv/tb_eeprom_write_coalescing_queue_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_eeprom_write_coalescing_queue_unit - self-checking bench for the queue
// drives write, tick, flush and leave requests with bursty pacing, tracks the
// queue contents and mode in a scoreboard and checks every result in order
// ---------------------------------------------------------------------------
module tb_eeprom_write_coalescing_queue_unit;
  import ewcq_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] device_addr;
    logic [7:0] mem_addr;
    logic [7:0] tx_data;
    status_t    status;
    logic       queue_empty;
    logic       last;
  } bus_result_t;

  // queue contents and mode, plus the results still owed by the block
  class ewcq_scoreboard;
    logic [10:0] slot_addr [QDEPTH];
    logic [7:0]  slot_data [QDEPTH];
    int          fill;
    bit          direct;
    bus_result_t owed_q[$];
    int          errors, requests, results, merges, drops, flush_runs, direct_writes;

    function void owe(bit txv, logic [10:0] a, logic [7:0] d, status_t st, bit fin);
      bus_result_t r;
      r.tx_valid    = txv;
      r.device_addr = txv ? (DEV_BASE | {4'b0000, a[10:8], 1'b0}) : 8'h00;
      r.mem_addr    = txv ? a[7:0] : 8'h00;
      r.tx_data     = txv ? d : 8'h00;
      r.status      = st;
      r.queue_empty = (fill == 0);
      r.last        = fin;
      owed_q.push_back(r);
    endfunction

    function void pop_oldest(output logic [10:0] a, output logic [7:0] d);
      a = slot_addr[0];
      d = slot_data[0];
      for (int i = 1; i < fill; i++) begin
        slot_addr[i-1] = slot_addr[i];
        slot_data[i-1] = slot_data[i];
      end
      fill--;
    endfunction

    // work out the results of one accepted request
    function void note_request(cmd_t c, logic [10:0] a, logic [7:0] d);
      int          hit;
      logic [10:0] pa;
      logic [7:0]  pd;
      requests++;
      case (c)
        CMD_WRITE: begin
          if (direct) begin
            direct_writes++;
            owe(1'b1, a, d, ST_DONE, 1'b1);
          end else begin
            hit = -1;
            for (int i = 0; i < fill; i++)
              if (hit < 0 && slot_addr[i] == a) hit = i;
            if (hit >= 0) begin
              slot_data[hit] = d;
              merges++;
              owe(1'b0, '0, '0, ST_MERGED, 1'b1);
            end else if (fill < QDEPTH) begin
              slot_addr[fill] = a;
              slot_data[fill] = d;
              fill++;
              owe(1'b0, '0, '0, ST_NEW, 1'b1);
            end else begin
              drops++;
              owe(1'b0, '0, '0, ST_FULL, 1'b1);
            end
          end
        end
        CMD_TICK: begin
          if (fill == 0) begin
            owe(1'b0, '0, '0, ST_DONE, 1'b1);
          end else begin
            pop_oldest(pa, pd);
            owe(1'b1, pa, pd, ST_DONE, 1'b1);
          end
        end
        CMD_FLUSH: begin
          if (fill == 0) owe(1'b0, '0, '0, ST_DONE, 1'b1);
          else flush_runs++;
          while (fill > 0) begin
            pop_oldest(pa, pd);
            owe(1'b1, pa, pd, ST_DONE, fill == 0);
          end
          direct = 1'b1;
        end
        default: begin
          direct = 1'b0;
          owe(1'b0, '0, '0, ST_DONE, 1'b1);
        end
      endcase
    endfunction

    function void cmp(string fld, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fld, want, got);
      end
    endfunction

    // compare a result with the oldest owed one
    function void check_result(bus_result_t got);
      bus_result_t want;
      results++;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = owed_q.pop_front();
      cmp("tx_valid", want.tx_valid, got.tx_valid);
      cmp("device_addr", want.device_addr, got.device_addr);
      cmp("mem_addr", want.mem_addr, got.mem_addr);
      cmp("tx_data", want.tx_data, got.tx_data);
      cmp("status", want.status, got.status);
      cmp("queue_empty", want.queue_empty, got.queue_empty);
      cmp("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  ewcq_req_if req ();
  ewcq_rsp_if rsp ();

  eeprom_write_coalescing_queue_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  ewcq_scoreboard sb = new();
  int             burst_left = 0;
  logic [5:0]     stall_tick = '0;
  logic [15:0]    ready_pattern = '1;

  always #5 clk = ~clk;

  // receiver stalls on a pattern that changes each time the 6-bit stall tick wraps
  always @(posedge clk) begin
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == 6'd0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= 16'hFFFF;
        1: ready_pattern <= 16'($urandom);
        2: ready_pattern <= 16'($urandom | $urandom);
        default: ready_pattern <= 16'($urandom & $urandom);
      endcase
    end
    rsp.ready <= ready_pattern[stall_tick[3:0]];
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result({rsp.tx_valid, rsp.device_addr, rsp.mem_addr, rsp.tx_data,
                       status_t'(rsp.status), rsp.queue_empty, rsp.last});
  end

  // one request, with a random gap once a burst is used up
  task automatic send(cmd_t c, logic [10:0] a, logic [7:0] d);
    req.valid     <= 1'b1;
    req.cmd       <= c;
    req.byte_addr <= a;
    req.byte_data <= d;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(c, a, d);
    burst_left--;
    if (burst_left <= 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // hold off until every owed result has arrived
  task automatic drain_pause();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.owed_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [10:0] addr_pool [28];
    int          pool_n, tick_pct, run_len, roll, episode;
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.cmd       <= CMD_WRITE;
    req.byte_addr <= '0;
    req.byte_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty tick and leave, new, merge, pop
    send(CMD_TICK, 11'h000, 8'h00);
    send(CMD_LEAVE, 11'h7FF, 8'hFF);
    send(CMD_WRITE, 11'h000, 8'h00);
    send(CMD_WRITE, 11'h7FF, 8'hFF);
    send(CMD_WRITE, 11'h000, 8'hA5);
    send(CMD_TICK, 11'h000, 8'h00);
    // fill every slot, drop one, merge into a full queue, flush all
    for (int i = 1; i < QDEPTH; i++) send(CMD_WRITE, 11'(i * 129), 8'(i * 17));
    send(CMD_WRITE, 11'h0AA, 8'h11);
    send(CMD_WRITE, 11'h7FF, 8'h3C);
    send(CMD_FLUSH, 11'h000, 8'h00);
    // direct mode: write, empty tick, empty flush, leave
    send(CMD_WRITE, 11'h555, 8'h5A);
    send(CMD_TICK, 11'h2AA, 8'hC3);
    send(CMD_FLUSH, 11'h000, 8'h00);
    send(CMD_LEAVE, 11'h000, 8'h00);
    drain_pause();

    // random episodes: fill with a small address pool, then tick or flush
    episode = 0;
    while (sb.requests < 480) begin
      pool_n   = $urandom_range(1, 28);
      tick_pct = $urandom_range(0, 30);
      run_len  = $urandom_range(1, 40);
      for (int i = 0; i < pool_n; i++) addr_pool[i] = 11'($urandom_range(0, 2047));
      for (int k = 0; k < run_len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5)
          send(cmd_t'($urandom_range(0, 3)), 11'($urandom_range(0, 2047)), 8'($urandom));
        else if (roll < 5 + tick_pct)
          send(CMD_TICK, 11'($urandom_range(0, 2047)), 8'($urandom));
        else
          send(CMD_WRITE, addr_pool[$urandom_range(0, pool_n - 1)], 8'($urandom));
      end
      if ($urandom_range(0, 99) < 60) begin
        send(CMD_FLUSH, 11'($urandom_range(0, 2047)), 8'($urandom));
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0)
            send(cmd_t'($urandom_range(1, 2)), 11'($urandom_range(0, 2047)), 8'($urandom));
          else
            send(CMD_WRITE, 11'($urandom_range(0, 2047)), 8'($urandom));
        end
        send(CMD_LEAVE, 11'($urandom_range(0, 2047)), 8'($urandom));
      end
      episode++;
      if (episode % 9 == 4) drain_pause();
    end

    // wind down: all results in, then idle before printing the summary
    req.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d requests: %0d merges, %0d drops on a full queue, %0d flush runs,",
             sb.requests, sb.merges, sb.drops, sb.flush_runs);
    $display("%0d direct writes; checked %0d results, %0d mismatches",
             sb.direct_writes, sb.results, sb.errors);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #6000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
